// ----- rtl/jlex_pkg.sv -----
package jlex_pkg;

   // token store limit; at most TOKEN_BYTES-1 bytes are kept per token
   localparam int TOKEN_BYTES = 64;
   localparam int LEN_W       = $clog2(TOKEN_BYTES);

   // result queue between front and back, power of two
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);

   // token kinds
   localparam logic [3:0] KIND_NONE    = 4'd0;
   localparam logic [3:0] KIND_END     = 4'd1;
   localparam logic [3:0] KIND_UNKNOWN = 4'd2;
   localparam logic [3:0] KIND_STRING  = 4'd3;
   localparam logic [3:0] KIND_NUMBER  = 4'd4;
   localparam logic [3:0] KIND_LITERAL = 4'd5;
   localparam logic [3:0] KIND_TRUE    = 4'd6;
   localparam logic [3:0] KIND_FALSE   = 4'd7;
   localparam logic [3:0] KIND_NULL    = 4'd8;
   localparam logic [3:0] KIND_PUNCT   = 4'd9;   // [ ] { } , : follow in that order

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic [3:0] token_kind;
      logic [5:0] token_length;
   } result_type;

   // one accepted request's results: one or two
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_type;

endpackage

// ----- rtl/jlex_front.sv -----
module jlex_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          char_byte,
   input  logic                end_of_input,
   input  logic                queue_full,
   output jlex_pkg::queue_type push
);
   import jlex_pkg::*;

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_STRING  = 2'd1;
   localparam logic [1:0] MODE_NUMBER  = 2'd2;
   localparam logic [1:0] MODE_LITERAL = 2'd3;

   localparam logic [2:0] PH_INIT = 3'd0;
   localparam logic [2:0] PH_SIGN = 3'd1;
   localparam logic [2:0] PH_ZERO = 3'd2;
   localparam logic [2:0] PH_DEC  = 3'd3;
   localparam logic [2:0] PH_HEX  = 3'd4;

   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(TOKEN_BYTES - 1);

   localparam logic [7:0] KW_TEXT [3][8] = '{
      '{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
      '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam int unsigned KW_LEN [3]  = '{5, 4, 4};
   localparam logic [3:0]  KW_KIND [3] = '{KIND_FALSE, KIND_TRUE, KIND_NULL};
   localparam logic [7:0]  PUNCT [6]   = '{"[", "]", "{", "}", ",", ":"};

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_xdigit(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   // KIND_NONE when not punctuation
   function automatic logic [3:0] punct_kind(logic [7:0] c);
      logic [3:0] kind;
      kind = KIND_NONE;
      for (int k = 5; k >= 0; k--)
         if (PUNCT[k] == c) kind = KIND_PUNCT + 4'(k);
      return kind;
   endfunction

   // bit 3 set: character ends the number
   function automatic logic [3:0] number_next(logic [2:0] ph, logic [7:0] c);
      logic [3:0] nx;
      nx = 4'b1000;
      unique case (ph)
         PH_INIT: begin
            if (c == "-") nx = {1'b0, PH_SIGN};
            else if (c == "0") nx = {1'b0, PH_ZERO};
            else if (is_digit(c)) nx = {1'b0, PH_DEC};
         end
         PH_SIGN: begin
            if (c == "0") nx = {1'b0, PH_ZERO};
            else if (is_digit(c)) nx = {1'b0, PH_DEC};
         end
         PH_ZERO: begin
            if (is_digit(c)) nx = {1'b0, PH_DEC};
            else if (c == "x" || c == "X") nx = {1'b0, PH_HEX};
         end
         PH_DEC:  if (is_digit(c)) nx = {1'b0, PH_DEC};
         PH_HEX:  if (is_xdigit(c)) nx = {1'b0, PH_HEX};
         default: nx = 4'b1000;
      endcase
      return nx;
   endfunction

   function automatic logic [2:0] kw_update(logic [2:0] km, logic [LEN_W-1:0] pos,
                                            logic [7:0] c);
      logic [2:0] m;
      m = km;
      for (int k = 0; k < 3; k++)
         if (!((32'(pos) < KW_LEN[k]) && (KW_TEXT[k][pos[2:0]] == c))) m[k] = 1'b0;
      return m;
   endfunction

   function automatic logic [3:0] literal_kind(logic [2:0] km, logic [LEN_W-1:0] pos);
      logic [3:0] kind;
      kind = KIND_LITERAL;
      for (int k = 2; k >= 0; k--)
         if (km[k] && 32'(pos) == KW_LEN[k]) kind = KW_KIND[k];
      return kind;
   endfunction

   function automatic result_type make_res(logic [7:0] b, logic v, logic [3:0] kind,
                                           logic [LEN_W-1:0] len);
      result_type r;
      r.text_byte    = b;
      r.byte_valid   = v;
      r.token_kind   = kind;
      r.token_length = 6'(32'(len));
      return r;
   endfunction

   logic [1:0]       mode_ff, mode_in;
   logic             esc_ff, esc_in;
   logic [2:0]       phase_ff, phase_in;
   logic [LEN_W-1:0] slen_ff, slen_in;
   logic [2:0]       km_ff, km_in;

   result_type res [2];
   logic [1:0] n;
   logic       do_start;
   logic [7:0] b;
   logic [3:0] nx;
   logic [3:0] pk;
   logic       take;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;

   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      phase_in = phase_ff;
      slen_in  = slen_ff;
      km_in    = km_ff;
      res[0]   = '0;
      res[1]   = '0;
      n        = 2'd0;
      do_start = 1'b0;
      b        = char_byte;
      nx       = number_next(phase_ff, char_byte);
      pk       = punct_kind(char_byte);

      if (end_of_input) begin
         unique case (mode_ff)
            MODE_STRING: begin
               res[0] = make_res(8'h00, 1'b0, KIND_STRING, slen_ff);
               n = 2'd1;
            end
            MODE_NUMBER: begin
               res[0] = make_res(8'h00, 1'b0, KIND_NUMBER, slen_ff);
               n = 2'd1;
            end
            MODE_LITERAL: begin
               res[0] = make_res(8'h00, 1'b0, literal_kind(km_ff, slen_ff), slen_ff);
               n = 2'd1;
            end
            default: n = 2'd0;
         endcase
         mode_in  = MODE_START;
         esc_in   = 1'b0;
         res[n[0]] = make_res(8'h00, 1'b0, KIND_END, '0);
         n = n + 2'd1;
      end else begin
         unique case (mode_ff)
            MODE_START: do_start = 1'b1;
            MODE_STRING: begin
               if (esc_ff) begin
                  esc_in = 1'b0;
                  unique case (char_byte)
                     "b":     b = 8'h08;
                     "f":     b = 8'h0C;
                     "n":     b = 8'h0A;
                     "r":     b = 8'h0D;
                     "t":     b = 8'h09;
                     default: b = char_byte;
                  endcase
                  // \u is kept as backslash then u
                  if (char_byte == "u" && slen_in < LEN_MAX) begin
                     slen_in = slen_in + LEN_W'(1);
                     res[n[0]] = make_res("\\", 1'b1, KIND_NONE, '0);
                     n = n + 2'd1;
                  end
                  if (slen_in < LEN_MAX) begin
                     slen_in = slen_in + LEN_W'(1);
                     res[n[0]] = make_res(b, 1'b1, KIND_NONE, '0);
                     n = n + 2'd1;
                  end
               end else if (char_byte == "\\") begin
                  esc_in = 1'b1;
               end else if (char_byte == "\"") begin
                  res[0]  = make_res(8'h00, 1'b0, KIND_STRING, slen_ff);
                  n       = 2'd1;
                  mode_in = MODE_START;
               end else if (slen_ff < LEN_MAX) begin
                  slen_in = slen_ff + LEN_W'(1);
                  res[0]  = make_res(char_byte, 1'b1, KIND_NONE, '0);
                  n       = 2'd1;
               end
            end
            MODE_NUMBER: begin
               if (!nx[3]) begin
                  phase_in = nx[2:0];
                  if (slen_ff < LEN_MAX) begin
                     slen_in = slen_ff + LEN_W'(1);
                     res[0]  = make_res(char_byte, 1'b1, KIND_NONE, '0);
                     n       = 2'd1;
                  end
               end else begin
                  res[0]   = make_res(8'h00, 1'b0, KIND_NUMBER, slen_ff);
                  n        = 2'd1;
                  mode_in  = MODE_START;
                  do_start = 1'b1;
               end
            end
            MODE_LITERAL: begin
               if (is_alpha(char_byte) ||
                   (slen_ff != '0 && (is_digit(char_byte) || char_byte == "_"))) begin
                  km_in = kw_update(km_ff, slen_ff, char_byte);
                  if (slen_ff < LEN_MAX) begin
                     slen_in = slen_ff + LEN_W'(1);
                     res[0]  = make_res(char_byte, 1'b1, KIND_NONE, '0);
                     n       = 2'd1;
                  end
               end else begin
                  res[0]   = make_res(8'h00, 1'b0, literal_kind(km_ff, slen_ff), slen_ff);
                  n        = 2'd1;
                  mode_in  = MODE_START;
                  do_start = 1'b1;
               end
            end
            default: do_start = 1'b0;
         endcase

         // start of a token; also the character that closed a number or literal
         if (do_start && !is_blank(char_byte)) begin
            slen_in = '0;
            if (pk != KIND_NONE) begin
               slen_in = LEN_W'(1);
               res[n[0]] = make_res(char_byte, 1'b1, pk, LEN_W'(1));
               n = n + 2'd1;
            end else if (char_byte == "\"") begin
               mode_in = MODE_STRING;
               esc_in  = 1'b0;
            end else if (is_digit(char_byte) || char_byte == "-") begin
               mode_in  = MODE_NUMBER;
               phase_in = 3'(number_next(PH_INIT, char_byte));
               slen_in  = LEN_W'(1);
               res[n[0]] = make_res(char_byte, 1'b1, KIND_NONE, '0);
               n = n + 2'd1;
            end else if (is_alpha(char_byte)) begin
               mode_in = MODE_LITERAL;
               km_in   = kw_update(3'b111, '0, char_byte);
               slen_in = LEN_W'(1);
               res[n[0]] = make_res(char_byte, 1'b1, KIND_NONE, '0);
               n = n + 2'd1;
            end else begin
               slen_in = LEN_W'(1);
               res[n[0]] = make_res(char_byte, 1'b1, KIND_UNKNOWN, LEN_W'(1));
               n = n + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_START;
         esc_ff   <= 1'b0;
         phase_ff <= PH_INIT;
         slen_ff  <= '0;
         km_ff    <= 3'b111;
      end else if (take) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         phase_ff <= phase_in;
         slen_ff  <= slen_in;
         km_ff    <= km_in;
      end
   end

   always_comb begin
      push.valid        = take && (n != 2'd0);
      push.entry.two    = n[1];
      push.entry.first  = res[0];
      push.entry.second = res[1];
   end

   // the store never runs past its limit
   a_len_limit: assert property (@(posedge clock) disable iff (reset)
      slen_ff <= LEN_MAX)
      else $error("token length beyond store limit");

   // blank outside a token never produces a result
   a_blank_quiet: assert property (@(posedge clock) disable iff (reset)
      take && !end_of_input && mode_ff == MODE_START && is_blank(char_byte) |-> !push.valid)
      else $error("result from blank character");

endmodule

// ----- rtl/jlex_queue.sv -----
module jlex_queue (
   input  logic                clock,
   input  logic                reset,
   input  jlex_pkg::queue_type push,
   input  logic                pop,
   output logic                full,
   output jlex_pkg::queue_type head
);
   import jlex_pkg::*;

   entry_type        store_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_pop;

   assign full       = count_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.entry = store_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W + 1)'(push.valid) - (PTR_W + 1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) store_ff[wr_ptr_ff] <= push.entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("push into full queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W + 1)'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

// ----- rtl/jlex_back.sv -----
module jlex_back (
   input  logic                clock,
   input  logic                reset,
   input  jlex_pkg::queue_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // text_byte[7:0], token_length[13:8], zero
   output logic [4:0]          rsp_tuser,   // byte_valid[0], token_kind[4:1]
   output logic                rsp_tlast
);
   import jlex_pkg::*;

   logic       out_v_ff, out_v_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;
   logic       pend_v_ff, pend_v_in;
   result_type pend_ff, pend_in;
   logic       free;

   assign free = !out_v_ff || rsp_tready;
   assign pop  = free && !pend_v_ff && head.valid;

   always_comb begin
      out_v_in    = out_v_ff;
      out_in      = out_ff;
      out_last_in = out_last_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      if (free) begin
         priority if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_in      = pend_ff;
            out_last_in = 1'b1;
            pend_v_in   = 1'b0;
         end else if (head.valid) begin
            out_v_in    = 1'b1;
            out_in      = head.entry.first;
            out_last_in = !head.entry.two;
            pend_v_in   = head.entry.two;
            pend_in     = head.entry.second;
         end else begin
            out_v_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
      pend_ff     <= pend_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_ff.token_length, out_ff.text_byte};
   assign rsp_tuser  = {out_ff.token_kind, out_ff.byte_valid};
   assign rsp_tlast  = out_last_ff;

   // a held second result always sits behind a shown first one
   a_pend_behind: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> out_v_ff && !out_last_ff)
      else $error("second result without first");

   a_not_last_has_pend: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !out_last_ff |-> pend_v_ff)
      else $error("non-final result with nothing behind it");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> out_v_ff)
      else $error("popped entry not shown");

endmodule

// ----- rtl/json_lexer.sv -----
// JSON lexer: one character per request on the req_ channel, tokens out on rsp_.
// A request carries a character byte in req_tdata, or an end-of-input mark in
// req_tuser (the byte is then ignored). Each request yields zero, one or two
// results: stored token bytes (byte_valid set) and token ends (kind, length).
// rsp_tlast marks the final result belonging to one request.
// The front lexes a request in the cycle it is accepted and writes its results
// as one entry into a four-entry queue; the back drains the queue through an
// output register, one result per cycle while the receiver is ready.
// A request's results pass through its queue entry and then the output register.
// Throughput: one request per cycle while the queue has room; a request with
// two results holds the output for both of them, so the sustained rate is set
// by the single result port.
// req_tready drops only when the queue is full; a stalled receiver fills the
// queue and then holds off requests, with nothing lost or repeated.
// Reset is synchronous and active high: lexer back to start of token, queue
// and output emptied; no clearing pass is needed.
module json_lexer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // char_byte[7:0]
   input  logic        req_tuser,    // end_of_input[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // text_byte[7:0], token_length[13:8], zero[15:14]
   output logic [4:0]  rsp_tuser,    // byte_valid[0], token_kind[4:1]
   output logic        rsp_tlast
);
   import jlex_pkg::*;

   queue_type push;
   queue_type head;
   logic      queue_full;
   logic      pop;

   // front: lexer state and result building
   jlex_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .char_byte    (req_tdata),
      .end_of_input (req_tuser),
      .queue_full   (queue_full),
      .push         (push)
   );

   // decouples lexing from a stalled receiver
   jlex_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // back: serialises one or two results per entry
   jlex_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import jlex_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_LIMIT  = 300;

   typedef enum logic [1:0] {LEX_START, LEX_STRING, LEX_NUMBER, LEX_LITERAL} lex_state_type;
   typedef enum logic [2:0] {NUM_BEGIN, NUM_SIGN, NUM_ZERO, NUM_DEC, NUM_HEX, NUM_END}
      num_phase_type;

   typedef struct {
      logic [7:0]       text_byte;
      logic             byte_valid;
      logic [3:0]       token_kind;
      logic [LEN_W-1:0] token_length;
      logic             last;
   } token_result_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;    // text_byte[7:0], token_length[13:8], zero[15:14]
   logic [4:0]  rsp_tuser;    // byte_valid[0], token_kind[4:1]
   logic        rsp_tlast;

   json_lexer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // lexer state as the predictor sees it
   lex_state_type    lex_state = LEX_START;
   logic             esc_seen  = 1'b0;
   num_phase_type    num_phase = NUM_BEGIN;
   logic [LEN_W-1:0] tok_len   = '0;
   logic [2:0]       kw_alive  = 3'b111;   // bit0 false, bit1 true, bit2 null

   token_result_type expected_tokens[$];
   token_result_type step_buf[2];
   int               step_n;

   int  sent_count  = 0;
   int  error_count = 0;
   int  rsp_hold    = 0;
   int  quiet_cycles = 0;
   bit  req_idle    = 1'b1;
   bit  rsp_idle    = 1'b1;

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c == " " || c == "\t" || c == "\n" || c == "\r";
   endfunction

   function automatic string keyword_word(int k);
      return (k == 0) ? "false" : (k == 1) ? "true" : "null";
   endfunction

   function automatic int punct_index(logic [7:0] c);
      string set = "[]{},:";
      for (int i = 0; i < set.len(); i++)
         if (set[i] == c) return i;
      return 6;
   endfunction

   function automatic logic [7:0] pick_char(string set);
      return set[$urandom_range(0, set.len() - 1)];
   endfunction

   function automatic void add_token_result(logic [7:0] b, logic v, logic [3:0] kind,
                                            logic [LEN_W-1:0] len);
      if (step_n < 2) begin
         step_buf[step_n] = '{b, v, kind, len, 1'b0};
         step_n++;
      end
   endfunction

   // bytes past the store limit are dropped silently
   function automatic void keep_text_byte(logic [7:0] b);
      if (tok_len < TOKEN_BYTES - 1) begin
         tok_len++;
         add_token_result(b, 1'b1, KIND_NONE, '0);
      end
   endfunction

   function automatic logic [3:0] literal_kind();
      if (kw_alive[0] && tok_len == 5) return KIND_FALSE;
      if (kw_alive[1] && tok_len == 4) return KIND_TRUE;
      if (kw_alive[2] && tok_len == 4) return KIND_NULL;
      return KIND_LITERAL;
   endfunction

   function automatic num_phase_type number_next(num_phase_type ph, logic [7:0] c);
      num_phase_type nx;
      nx = NUM_END;
      case (ph)
         NUM_BEGIN: begin
            if (c == "-") nx = NUM_SIGN;
            else if (c == "0") nx = NUM_ZERO;
            else if (is_digit(c)) nx = NUM_DEC;
         end
         NUM_SIGN: begin
            if (c == "0") nx = NUM_ZERO;
            else if (is_digit(c)) nx = NUM_DEC;
         end
         NUM_ZERO: begin
            if (is_digit(c)) nx = NUM_DEC;
            else if (c == "x" || c == "X") nx = NUM_HEX;
         end
         NUM_DEC: if (is_digit(c)) nx = NUM_DEC;
         NUM_HEX: if (is_hex(c)) nx = NUM_HEX;
         default: ;
      endcase
      return nx;
   endfunction

   // works out the results of one accepted request and queues them
   function automatic void lex_char(logic [7:0] ch, logic eoi);
      logic [7:0]    c;
      logic          again;
      int            idx;
      num_phase_type nx;
      string         w;
      c = ch;
      step_n = 0;
      if (eoi) begin
         case (lex_state)
            LEX_STRING:  add_token_result(8'h00, 1'b0, KIND_STRING, tok_len);
            LEX_NUMBER:  add_token_result(8'h00, 1'b0, KIND_NUMBER, tok_len);
            LEX_LITERAL: add_token_result(8'h00, 1'b0, literal_kind(), tok_len);
            default: ;
         endcase
         lex_state = LEX_START;
         esc_seen = 1'b0;
         add_token_result(8'h00, 1'b0, KIND_END, '0);
      end else begin
         // a character that closes a number or literal is looked at again
         for (int pass = 0; pass < 3; pass++) begin
            again = 1'b0;
            case (lex_state)
               LEX_START: begin
                  if (!is_blank(c)) begin
                     tok_len = '0;
                     idx = punct_index(c);
                     if (idx < 6) begin
                        tok_len = LEN_W'(1);
                        add_token_result(c, 1'b1, KIND_PUNCT + 4'(idx), LEN_W'(1));
                     end else if (c == "\"") begin
                        lex_state = LEX_STRING;
                        esc_seen = 1'b0;
                     end else if (is_digit(c) || c == "-") begin
                        lex_state = LEX_NUMBER;
                        num_phase = NUM_BEGIN;
                        again = 1'b1;
                     end else if (is_alpha(c)) begin
                        lex_state = LEX_LITERAL;
                        kw_alive = 3'b111;
                        again = 1'b1;
                     end else begin
                        tok_len = LEN_W'(1);
                        add_token_result(c, 1'b1, KIND_UNKNOWN, LEN_W'(1));
                     end
                  end
               end
               LEX_STRING: begin
                  if (esc_seen) begin
                     esc_seen = 1'b0;
                     case (c)
                        "b": c = 8'h08;
                        "f": c = 8'h0C;
                        "n": c = 8'h0A;
                        "r": c = 8'h0D;
                        "t": c = 8'h09;
                        "u": keep_text_byte("\\");
                        default: ;
                     endcase
                     keep_text_byte(c);
                  end else if (c == "\\") begin
                     esc_seen = 1'b1;
                  end else if (c == "\"") begin
                     add_token_result(8'h00, 1'b0, KIND_STRING, tok_len);
                     lex_state = LEX_START;
                  end else begin
                     keep_text_byte(c);
                  end
               end
               LEX_NUMBER: begin
                  nx = number_next(num_phase, c);
                  if (nx != NUM_END) begin
                     num_phase = nx;
                     keep_text_byte(c);
                  end else begin
                     add_token_result(8'h00, 1'b0, KIND_NUMBER, tok_len);
                     lex_state = LEX_START;
                     again = 1'b1;
                  end
               end
               default: begin
                  if (is_alpha(c) || (tok_len > 0 && (is_digit(c) || c == "_"))) begin
                     for (int k = 0; k < 3; k++) begin
                        w = keyword_word(k);
                        if (!(tok_len < w.len() && w[tok_len] == c)) kw_alive[k] = 1'b0;
                     end
                     keep_text_byte(c);
                  end else begin
                     add_token_result(8'h00, 1'b0, literal_kind(), tok_len);
                     lex_state = LEX_START;
                     again = 1'b1;
                  end
               end
            endcase
            if (!again) break;
         end
      end
      for (int i = 0; i < step_n; i++) begin
         step_buf[i].last = (i == step_n - 1);
         expected_tokens.push_back(step_buf[i]);
      end
   endfunction

   // one request; tvalid is left high so a back-to-back request follows cleanly
   task automatic send_char(input logic [7:0] ch, input logic eoi);
      int gap;
      gap = req_idle ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= eoi;
      do @(posedge clock); while (!req_tready);
      lex_char(ch, eoi);
      sent_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i], 1'b0);
   endtask

   task automatic test_punctuation();
      send_text("[]{},:");
   endtask

   task automatic test_blank_and_unknown();
      send_text(" \t");
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
   endtask

   task automatic test_string_escapes();
      send_text("\"\\u\\q\"");
   endtask

   task automatic test_number_ends();
      send_text("-0xF]");
   endtask

   task automatic test_literal_at_end();
      send_text("null");
      send_char(8'h00, 1'b1);
   endtask

   // mostly well-formed tokens with random content, some noise and cut-off input
   task automatic test_random_stream();
      logic [7:0] text_q[$];
      int         stop_at;
      int         kind_sel;
      int         len;
      logic       eoi;
      logic       open_string;
      string      word;
      stop_at = sent_count + RANDOM_ITEMS;
      while (sent_count < stop_at) begin
         text_q.delete();
         open_string = 1'b0;
         if ($urandom_range(0, 31) == 0) begin
            req_idle = $urandom_range(0, 1);
            rsp_idle = $urandom_range(0, 1);
         end
         kind_sel = $urandom_range(0, 99);
         if (kind_sel < 12) begin
            text_q.push_back(pick_char("[]{},:"));
         end else if (kind_sel < 20) begin
            text_q.push_back(pick_char(" \t\n\r"));
         end else if (kind_sel < 40) begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 72) : $urandom_range(0, 8);
            text_q.push_back("\"");
            repeat (len) begin
               case ($urandom_range(0, 5))
                  0: begin
                     text_q.push_back("\\");
                     if ($urandom_range(0, 4) == 0) text_q.push_back(8'($urandom_range(0, 255)));
                     else text_q.push_back(pick_char("bfnrtu\\\"/"));
                  end
                  1: text_q.push_back(8'($urandom_range(0, 255)));
                  default: text_q.push_back(pick_char("abcXYZ019 .-_{}[]:,"));
               endcase
            end
            if ($urandom_range(0, 9) != 0) begin
               text_q.push_back("\"");
            end else begin
               open_string = 1'b1;
               if ($urandom_range(0, 1)) text_q.push_back("\\");
            end
         end else if (kind_sel < 58) begin
            if ($urandom_range(0, 2) == 0) text_q.push_back("-");
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 5);
            if ($urandom_range(0, 11) != 0) begin
               if ($urandom_range(0, 2) == 0) begin
                  text_q.push_back("0");
                  if ($urandom_range(0, 3) != 0) begin
                     text_q.push_back($urandom_range(0, 1) ? "x" : "X");
                     repeat (len) text_q.push_back(pick_char("0123456789abcdefABCDEF"));
                  end else begin
                     repeat (len) text_q.push_back(pick_char("0123456789"));
                  end
               end else begin
                  text_q.push_back(pick_char("123456789"));
                  repeat (len) text_q.push_back(pick_char("0123456789"));
               end
            end
         end else if (kind_sel < 80) begin
            word = keyword_word($urandom_range(0, 2));
            for (int k = 0; k < word.len(); k++) text_q.push_back(word[k]);
            case ($urandom_range(0, 5))
               0, 1: ;
               2: void'(text_q.pop_back());
               3: repeat ($urandom_range(1, 3))
                     text_q.push_back(pick_char("abelrsux019_"));
               4: text_q[0] = text_q[0] ^ 8'h20;
               default: begin
                  text_q.delete();
                  text_q.push_back(pick_char("abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ"));
                  len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                    : $urandom_range(0, 6);
                  repeat (len) text_q.push_back(pick_char("aeflnrstuzAZ0189_"));
               end
            endcase
         end else if (kind_sel < 95) begin
            text_q.push_back(8'($urandom_range(0, 255)));
         end
         // numbers and literals end on a blank, a punctuation mark or the next token
         if (kind_sel >= 40 && kind_sel < 80) begin
            case ($urandom_range(0, 3))
               0: text_q.push_back(pick_char(" \t\n\r"));
               1: text_q.push_back(pick_char("[]{},:"));
               default: ;
            endcase
         end
         eoi = (kind_sel >= 95) || (open_string && $urandom_range(0, 1));
         foreach (text_q[i]) send_char(text_q[i], 1'b0);
         if (eoi) send_char(8'($urandom_range(0, 255)), 1'b1);
      end
   endtask

   // while rsp_idle is set, the receiver stalls a random number of cycles after each result
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         rsp_hold = rsp_idle ? $urandom_range(0, 7) : 0;
         if (rsp_hold != 0) rsp_tready <= 1'b0;
      end else if (rsp_hold != 0) begin
         rsp_hold = rsp_hold - 1;
         if (rsp_hold == 0) rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      token_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tokens.size() == 0) begin
            $error("result with none expected: text_byte %0h token_kind %0d",
                   rsp_tdata[7:0], rsp_tuser[4:1]);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_tdata[7:0] !== want.text_byte) begin
               $error("text_byte: expected %0h, got %0h", want.text_byte, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tuser[0] !== want.byte_valid) begin
               $error("byte_valid: expected %0d, got %0d", want.byte_valid, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tuser[4:1] !== want.token_kind) begin
               $error("token_kind: expected %0d, got %0d", want.token_kind, rsp_tuser[4:1]);
               error_count++;
            end
            if (rsp_tdata[13:8] !== want.token_length) begin
               $error("token_length: expected %0d, got %0d", want.token_length,
                      rsp_tdata[13:8]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_punctuation();
      test_blank_and_unknown();
      test_string_escapes();
      test_number_ends();
      test_literal_at_end();
      test_random_stream();
      req_tvalid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
